FILE: sv/tcpt_pkg.sv
package tcpt_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 256;

	typedef enum logic [2:0] {
		ST_FWD_UPDATE  = 3'd0,
		ST_REV_UPDATE  = 3'd1,
		ST_CREATED     = 3'd2,
		ST_FROZEN      = 3'd3,
		ST_TABLE_FULL  = 3'd4,
		ST_READ_OK     = 3'd5,
		ST_READ_UNUSED = 3'd6
	} status_t;

	typedef enum logic {
		ACT_PACKET = 1'b0,
		ACT_READ   = 1'b1
	} action_t;

	typedef struct packed {
		logic        action;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [47:0] timestamp_us;
		logic [3:0]  header_words;
		logic        syn_flag;
		logic        fin_flag;
		logic        rst_flag;
		logic [15:0] window_size;
		logic [7:0]  read_index;
	} req_t;

	typedef struct packed {
		logic [7:0]  entry_index;
		status_t     status;
		logic [23:0] packets_fwd;
		logic [23:0] packets_rev;
		logic [31:0] bytes_fwd;
		logic [31:0] bytes_rev;
		logic [47:0] duration_us;
		logic [4:0]  state_flags;
		logic [15:0] window_min;
		logic [15:0] window_max;
		logic [39:0] window_total;
	} rsp_t;

	// per-entry statistics, one memory word
	typedef struct packed {
		logic [23:0] fwd_packets;
		logic [23:0] rev_packets;
		logic [31:0] fwd_bytes;
		logic [31:0] rev_bytes;
		logic [47:0] first_time;
		logic [47:0] last_time;
		logic [1:0]  syn_count;
		logic [1:0]  fin_count;
		logic        fin_src;
		logic        fin_dst;
		logic        reset_seen;
		logic [15:0] min_window;
		logic [15:0] max_window;
		logic [39:0] sum_window;
	} stat_rec_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_KEY_RD,
		S_KEY_CMP,
		S_STAT_RD,
		S_UPDATE,
		S_CREATE,
		S_READ_RD,
		S_READ_OUT,
		S_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic load_req;
		logic inc_idx;
		logic key_rd;
		logic stat_rd;
		logic stat_rd_sel_read;
		logic update;
		logic create;
		logic read_out;
		logic set_full;
		logic set_unused;
	} cmd_t;

	typedef struct packed {
		logic is_read;
		logic read_ok;
		logic count_zero;
		logic hit;
		logic last_idx;
		logic full;
	} sts_t;

endpackage

FILE: sv/tcpt_ctrl.sv
module tcpt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  tcpt_pkg::sts_t sts,
	output tcpt_pkg::cmd_t cmd
);

	tcpt_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcpt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		unique case (state_q)
			tcpt_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = tcpt_pkg::S_DISPATCH;
				end
			end
			tcpt_pkg::S_DISPATCH: begin
				if (sts.is_read) begin
					if (sts.read_ok) begin
						state_d = tcpt_pkg::S_READ_RD;
					end else begin
						cmd.set_unused = 1'b1;
						state_d        = tcpt_pkg::S_OUT;
					end
				end else if (sts.count_zero) begin
					state_d = tcpt_pkg::S_CREATE;
				end else begin
					state_d = tcpt_pkg::S_KEY_RD;
				end
			end
			tcpt_pkg::S_KEY_RD: begin
				cmd.key_rd = 1'b1;
				state_d    = tcpt_pkg::S_KEY_CMP;
			end
			tcpt_pkg::S_KEY_CMP: begin
				if (sts.hit) begin
					state_d = tcpt_pkg::S_STAT_RD;
				end else if (sts.last_idx) begin
					if (sts.full) begin
						cmd.set_full = 1'b1;
						state_d      = tcpt_pkg::S_OUT;
					end else begin
						state_d = tcpt_pkg::S_CREATE;
					end
				end else begin
					cmd.inc_idx = 1'b1;
					state_d     = tcpt_pkg::S_KEY_RD;
				end
			end
			tcpt_pkg::S_STAT_RD: begin
				cmd.stat_rd = 1'b1;
				state_d     = tcpt_pkg::S_UPDATE;
			end
			tcpt_pkg::S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = tcpt_pkg::S_OUT;
			end
			tcpt_pkg::S_CREATE: begin
				cmd.create = 1'b1;
				state_d    = tcpt_pkg::S_OUT;
			end
			tcpt_pkg::S_READ_RD: begin
				cmd.stat_rd          = 1'b1;
				cmd.stat_rd_sel_read = 1'b1;
				state_d              = tcpt_pkg::S_READ_OUT;
			end
			tcpt_pkg::S_READ_OUT: begin
				cmd.read_out = 1'b1;
				state_d      = tcpt_pkg::S_OUT;
			end
			tcpt_pkg::S_OUT: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					state_d = tcpt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tcpt_pkg::S_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/tcpt_dp.sv
module tcpt_dp #(
	parameter int unsigned TABLE_ENTRIES = tcpt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tcpt_pkg::req_t req,
	input  tcpt_pkg::cmd_t cmd,
	output tcpt_pkg::sts_t sts,
	output tcpt_pkg::rsp_t rsp
);

	localparam int unsigned IW   = $clog2(TABLE_ENTRIES);
	localparam int unsigned CW   = IW + 1;
	localparam int unsigned CMPW = (CW > 8) ? CW : 8;

	tcpt_pkg::req_t      req_q;
	tcpt_pkg::rsp_t      rsp_q;
	logic [IW-1:0]       idx_q;
	logic [CW-1:0]       count_q;
	logic [95:0]         key_mem [TABLE_ENTRIES];
	logic [95:0]         key_rdata_q;
	tcpt_pkg::stat_rec_t stat_mem [TABLE_ENTRIES];
	tcpt_pkg::stat_rec_t stat_rdata_q;

	logic [IW-1:0]       new_idx;
	logic [IW-1:0]       rd_idx;
	logic [IW-1:0]       stat_rd_addr;
	logic [IW-1:0]       stat_wr_addr;
	logic [95:0]         fwd_key;
	logic [95:0]         rev_key;
	logic                fwd_hit;
	logic                rev_hit;
	logic                frozen;
	logic [5:0]          hdr_bytes;
	tcpt_pkg::stat_rec_t upd_rec;
	tcpt_pkg::stat_rec_t new_rec;
	logic [24:0]         pkt_sum;
	logic [32:0]         byte_sum;
	logic [40:0]         win_sum;
	logic [23:0]         pkt_cur;
	logic [31:0]         byte_cur;

	function automatic tcpt_pkg::rsp_t emit(input tcpt_pkg::stat_rec_t r, input logic [7:0] e,
			input tcpt_pkg::status_t s);
		tcpt_pkg::rsp_t o;
		o.entry_index  = e;
		o.status       = s;
		o.packets_fwd  = r.fwd_packets;
		o.packets_rev  = r.rev_packets;
		o.bytes_fwd    = r.fwd_bytes;
		o.bytes_rev    = r.rev_bytes;
		o.duration_us  = r.last_time - r.first_time;
		o.state_flags  = {r.reset_seen, r.fin_count, r.syn_count};
		o.window_min   = r.min_window;
		o.window_max   = r.max_window;
		o.window_total = r.sum_window;
		return o;
	endfunction

	assign new_idx      = count_q[IW-1:0];
	assign rd_idx       = IW'(req_q.read_index);
	assign stat_rd_addr = cmd.stat_rd_sel_read ? rd_idx : idx_q;
	assign stat_wr_addr = cmd.create ? new_idx : idx_q;
	assign hdr_bytes    = {req_q.header_words, 2'b00};
	assign fwd_key      = {req_q.src_addr, req_q.dst_addr, req_q.sport, req_q.dport};
	assign rev_key      = {req_q.dst_addr, req_q.src_addr, req_q.dport, req_q.sport};
	assign fwd_hit      = key_rdata_q == fwd_key;
	assign rev_hit      = key_rdata_q == rev_key;
	assign frozen       = stat_rdata_q.syn_count == 2'd2 && stat_rdata_q.fin_count == 2'd2;

	assign sts.is_read    = req_q.action == tcpt_pkg::ACT_READ;
	assign sts.read_ok    = CMPW'(req_q.read_index) < CMPW'(count_q);
	assign sts.count_zero = count_q == '0;
	assign sts.hit        = fwd_hit || rev_hit;
	assign sts.last_idx   = (CW'(idx_q) + CW'(1)) == count_q;
	assign sts.full       = count_q == CW'(TABLE_ENTRIES);

	assign rsp = rsp_q;

	// read-modify-write of a matched entry
	always_comb begin
		upd_rec  = stat_rdata_q;
		pkt_cur  = fwd_hit ? stat_rdata_q.fwd_packets : stat_rdata_q.rev_packets;
		byte_cur = fwd_hit ? stat_rdata_q.fwd_bytes : stat_rdata_q.rev_bytes;
		pkt_sum  = {1'b0, pkt_cur} + 25'd1;
		byte_sum = {1'b0, byte_cur} + 33'(hdr_bytes);
		win_sum  = {1'b0, stat_rdata_q.sum_window} + 41'(req_q.window_size);
		if (fwd_hit) begin
			upd_rec.fwd_packets = pkt_sum[24] ? '1 : pkt_sum[23:0];
			upd_rec.fwd_bytes   = byte_sum[32] ? '1 : byte_sum[31:0];
			if (req_q.fin_flag) upd_rec.fin_src = 1'b1;
		end else begin
			upd_rec.rev_packets = pkt_sum[24] ? '1 : pkt_sum[23:0];
			upd_rec.rev_bytes   = byte_sum[32] ? '1 : byte_sum[31:0];
			if (req_q.fin_flag) upd_rec.fin_dst = 1'b1;
			if (req_q.syn_flag && stat_rdata_q.syn_count != 2'd3) begin
				upd_rec.syn_count = stat_rdata_q.syn_count + 2'd1;
			end
		end
		if (req_q.timestamp_us < stat_rdata_q.first_time) upd_rec.first_time = req_q.timestamp_us;
		if (req_q.timestamp_us > stat_rdata_q.last_time) upd_rec.last_time = req_q.timestamp_us;
		upd_rec.fin_count = {1'b0, upd_rec.fin_src} + {1'b0, upd_rec.fin_dst};
		if (req_q.rst_flag) upd_rec.reset_seen = 1'b1;
		if (req_q.window_size < stat_rdata_q.min_window) upd_rec.min_window = req_q.window_size;
		if (req_q.window_size > stat_rdata_q.max_window) upd_rec.max_window = req_q.window_size;
		upd_rec.sum_window = win_sum[40] ? '1 : win_sum[39:0];
	end

	always_comb begin
		new_rec             = '0;
		new_rec.fwd_packets = 24'd1;
		new_rec.fwd_bytes   = 32'(hdr_bytes);
		new_rec.first_time  = req_q.timestamp_us;
		new_rec.last_time   = req_q.timestamp_us;
		new_rec.syn_count   = {1'b0, req_q.syn_flag};
		new_rec.fin_count   = {1'b0, req_q.fin_flag};
		new_rec.reset_seen  = req_q.rst_flag;
		new_rec.min_window  = req_q.window_size;
		new_rec.max_window  = req_q.window_size;
		new_rec.sum_window  = 40'(req_q.window_size);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.load_req) begin
				idx_q <= '0;
			end else if (cmd.inc_idx) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.create) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
		// an all-zero record gives all-zero statistics
		if (cmd.set_full) begin
			rsp_q <= emit('0, 8'd0, tcpt_pkg::ST_TABLE_FULL);
		end else if (cmd.set_unused) begin
			rsp_q <= emit('0, req_q.read_index, tcpt_pkg::ST_READ_UNUSED);
		end else if (cmd.create) begin
			rsp_q <= emit(new_rec, 8'(new_idx), tcpt_pkg::ST_CREATED);
		end else if (cmd.read_out) begin
			rsp_q <= emit(stat_rdata_q, req_q.read_index, tcpt_pkg::ST_READ_OK);
		end else if (cmd.update) begin
			if (frozen) begin
				rsp_q <= emit(stat_rdata_q, 8'(idx_q), tcpt_pkg::ST_FROZEN);
			end else begin
				rsp_q <= emit(upd_rec, 8'(idx_q),
					fwd_hit ? tcpt_pkg::ST_FWD_UPDATE : tcpt_pkg::ST_REV_UPDATE);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.create) begin
			key_mem[new_idx] <= fwd_key;
		end
		if (cmd.key_rd) begin
			key_rdata_q <= key_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.create) begin
			stat_mem[stat_wr_addr] <= new_rec;
		end else if (cmd.update && !frozen) begin
			stat_mem[stat_wr_addr] <= upd_rec;
		end
		if (cmd.stat_rd) begin
			stat_rdata_q <= stat_mem[stat_rd_addr];
		end
	end

endmodule

FILE: sv/tcp_connection_tracker.sv
// Bidirectional TCP flow table. One transaction is taken at a time: the next
// request is accepted only after the previous response has been taken. A read
// passes through dispatch, the statistics read and the output stage before the
// response is valid; an index not in use goes from dispatch to the response.
// A packet walks the occupied entries through the single-port key memory,
// with a key read and a compare per entry, until the first match, then does the
// statistics read-modify-write; after a miss a new entry is created, or the
// table full status is returned. No clearing pass is needed after reset.
module tcp_connection_tracker #(
	parameter int unsigned TABLE_ENTRIES = tcpt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tcpt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tcpt_pkg::rsp_t rsp
);

	tcpt_pkg::cmd_t cmd;
	tcpt_pkg::sts_t sts;

	tcpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tcpt_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

FILE: sv/tcpt_checker.sv
module tcpt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input tcpt_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input tcpt_pkg::rsp_t rsp
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one transaction in flight
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request accepted while response pending");

	a_no_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !rsp_valid)
		else $error("response too early");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == tcpt_pkg::ST_TABLE_FULL |->
		rsp.entry_index == 8'd0 && rsp.packets_fwd == 24'd0 && rsp.window_total == 40'd0)
		else $error("table full response not cleared");

	a_created: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == tcpt_pkg::ST_CREATED |->
		rsp.packets_fwd == 24'd1 && rsp.packets_rev == 24'd0 && rsp.duration_us == 48'd0)
		else $error("bad new entry statistics");

endmodule

bind tcp_connection_tracker tcpt_checker u_tcpt_checker (.*);
